### sv/d2dli_pkg.sv
// Package with the item layouts, state codes and message codes of the link initialization block.
`timescale 1ns / 1ps
`default_nettype none
package d2dli_pkg;

  typedef enum logic [4:0] {
    ST_START = 5'b00001,
    ST_RDI   = 5'b00010,
    ST_PARAM = 5'b00100,
    ST_FDI   = 5'b01000,
    ST_DONE  = 5'b10000
  } init_state_t;

  typedef enum logic [1:0] {
    SB_NONE = 2'd0,
    SB_CAP  = 2'd1,
    SB_REQ  = 2'd2,
    SB_RSP  = 2'd3
  } sb_msg_t;

  localparam logic [3:0] LINK_RESET     = 4'd0;
  localparam logic [3:0] RDI_STS_ACTIVE = 4'd1;
  localparam logic [3:0] FDI_REQ_NOP    = 4'd0;
  localparam logic [3:0] FDI_REQ_ACTIVE = 4'd1;
  localparam logic [3:0] FDI_STS_RESET  = 4'd0;
  localparam logic [3:0] FDI_STS_ACTIVE = 4'd1;
  localparam logic [3:0] RDI_REQ_NOP    = 4'd0;
  localparam logic [3:0] RDI_REQ_ACTIVE = 4'd1;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef struct packed {
    logic [3:0] fdi_state_request_prev;
    logic [3:0] fdi_state_request;
    logic       fdi_rxactive_status;
    logic       sideband_ready;
    logic [1:0] sideband_received;
    logic [3:0] rdi_status;
    logic       rdi_inband_present;
    logic [3:0] link_mode;
  } in_item_t;

  typedef struct packed {
    logic [1:0] sideband_send;
    logic       entry_done;
    logic [3:0] rdi_state_request;
    logic [3:0] fdi_status;
    logic       fdi_rxactive_request;
    logic       fdi_inband_present;
  } out_item_t;

  typedef struct packed {
    logic cap_received;
    logic cap_sent;
    logic peer_request_seen;
    logic peer_response_seen;
    logic response_sent;
    logic request_sent;
    logic activation_pending;
  } init_flags_t;

endpackage
`default_nettype wire

### sv/d2d_adapter_link_init_fsm.sv
// Top level of the die-to-die adapter link initialization controller.
//
//   Channel   Direction  Handshake                   Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  s_axis_tdata[23:0], one step of inputs
//   m_axis    out        m_axis_tvalid/m_axis_tready  m_axis_tdata[15:0], one step of outputs
//
// Each item passes an input register and a result register; one item per cycle is
// sustained while m_axis_tready stays high, and the controller updates its state per item.
// The synchronous reset clears both valid flags, the state machine and all flags.
// A stall on the output side holds the result; the input register takes one more item
// only if it is empty, after which s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module d2d_adapter_link_init_fsm
  import d2dli_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // Fields from bit 0 up: link_mode[3:0], rdi_inband_present[4], rdi_status[8:5],
  // sideband_received[10:9], sideband_ready[11], fdi_rxactive_status[12],
  // fdi_state_request[16:13], fdi_state_request_prev[20:17], ignored[23:21].
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // Fields from bit 0 up: fdi_inband_present[0], fdi_rxactive_request[1],
  // fdi_status[5:2], rdi_state_request[9:6], entry_done[10], sideband_send[12:11],
  // zero fill[15:13].
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  logic      in_valid;
  in_item_t  in_item;
  out_item_t out_item;
  out_item_t result;
  logic      advance;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  d2dli_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - $bits(out_item_t)){1'b0}}, out_item};

  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input side stalled while the result register is empty");

  a_entry_implies_active : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_item.entry_done) |->
      (out_item.fdi_rxactive_request && out_item.fdi_inband_present &&
       (out_item.fdi_status == FDI_STS_ACTIVE)))
    else $error("active entry reported without the FDI active outputs");

  a_send_needs_rdi_req : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_item.sideband_send != SB_NONE)) |->
      (out_item.rdi_state_request == RDI_REQ_ACTIVE))
    else $error("sideband message offered before RDI bring-up");

endmodule
`default_nettype wire

### sv/d2dli_ctrl.sv
// Initialization state machine with its handshake flags and the output decode.
`timescale 1ns / 1ps
`default_nettype none
module d2dli_ctrl
  import d2dli_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      advance,
  input  wire in_item_t  item,
  output out_item_t      result
);

  init_state_t state;
  init_state_t state_next;
  init_flags_t flags;
  init_flags_t flags_next;

  logic    in_reset;
  logic    rx_request;
  sb_msg_t send;

  always_comb begin
    in_reset   = (item.link_mode == LINK_RESET);
    rx_request = (state == ST_DONE) || ((state == ST_FDI) && flags.peer_request_seen);
    send       = SB_NONE;
    if (state == ST_PARAM) begin
      if (!flags.cap_sent) begin
        send = SB_CAP;
      end
    end else if (state == ST_FDI) begin
      if (item.fdi_rxactive_status && rx_request && !flags.response_sent) begin
        send = SB_RSP;
      end else if (flags.activation_pending && !flags.request_sent) begin
        send = SB_REQ;
      end
    end

    result = '0;
    if (in_reset) begin
      result.fdi_inband_present   = (state == ST_FDI) || (state == ST_DONE);
      result.fdi_rxactive_request = rx_request;
      result.fdi_status           = (state == ST_DONE) ? FDI_STS_ACTIVE : FDI_STS_RESET;
      result.rdi_state_request    = ((state == ST_RDI) || (state == ST_PARAM) ||
                                     (state == ST_FDI) || (state == ST_DONE)) ?
                                    RDI_REQ_ACTIVE : RDI_REQ_NOP;
      result.entry_done           = (state == ST_DONE);
      result.sideband_send        = send;
    end
  end

  always_comb begin
    state_next = state;
    flags_next = '0;
    if (in_reset) begin
      unique case (state)
        ST_START: begin
          if (item.rdi_inband_present) begin
            state_next = ST_RDI;
          end
        end
        ST_RDI: begin
          if (item.rdi_status == RDI_STS_ACTIVE) begin
            state_next = ST_PARAM;
          end
        end
        ST_PARAM: begin
          flags_next.cap_received = flags.cap_received ||
                                    (item.sideband_received == SB_CAP);
          flags_next.cap_sent     = flags.cap_sent ||
                                    (item.sideband_ready && (send == SB_CAP));
          if (flags.cap_sent && flags.cap_received) begin
            state_next = ST_FDI;
          end
        end
        ST_FDI: begin
          flags_next.peer_response_seen = flags.peer_response_seen ||
                                          (item.sideband_received == SB_RSP);
          flags_next.peer_request_seen  = flags.peer_request_seen ||
                                          (item.sideband_received == SB_REQ);
          flags_next.response_sent      = flags.response_sent ||
                                          ((send == SB_RSP) && item.sideband_ready);
          flags_next.request_sent       = flags.request_sent ||
                                          ((send == SB_REQ) && item.sideband_ready);
          flags_next.activation_pending = flags.activation_pending ||
                                          ((item.fdi_state_request == FDI_REQ_ACTIVE) &&
                                           (item.fdi_state_request_prev == FDI_REQ_NOP));
          if (flags.response_sent && flags.peer_response_seen) begin
            state_next = ST_DONE;
          end
        end
        ST_DONE: begin
          state_next = ST_DONE;
        end
        default: begin
          state_next = state;
        end
      endcase
    end else begin
      state_next = ST_START;
      flags_next = flags;
      flags_next.cap_received = 1'b0;
      flags_next.cap_sent     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
      flags <= '0;
    end else if (advance) begin
      state <= state_next;
      flags <= flags_next;
    end
  end

endmodule
`default_nettype wire

### bench/d2d_adapter_link_init_fsm_test.sv
// Testbench for the link initialization controller: directed bring-up walks, then random cycles.
`timescale 1ns / 1ps
module d2d_adapter_link_init_fsm_test;
  import d2dli_pkg::*;

  localparam int RANDOM_ITEMS = 1950;

  class link_init_scoreboard;
    init_state_t fsm;
    init_flags_t flg;
    out_item_t expected_outputs[$];
    int mismatches;
    int results;

    function new();
      fsm = ST_START;
      flg = '0;
      mismatches = 0;
      results = 0;
    endfunction

    // Works out the outputs of one controller step and advances the state.
    function void note_cycle(in_item_t it);
      out_item_t o;
      init_flags_t nf;
      init_state_t nxt;
      sb_msg_t send;
      o = '0;
      nf = '0;
      nxt = fsm;
      send = SB_NONE;
      if (it.link_mode == LINK_RESET) begin
        o.fdi_inband_present = (fsm == ST_FDI) || (fsm == ST_DONE);
        o.fdi_rxactive_request = (fsm == ST_DONE) || (fsm == ST_FDI && flg.peer_request_seen);
        o.fdi_status = (fsm == ST_DONE) ? FDI_STS_ACTIVE : FDI_STS_RESET;
        o.rdi_state_request = (fsm != ST_START) ? RDI_REQ_ACTIVE : RDI_REQ_NOP;
        o.entry_done = (fsm == ST_DONE);
        if (fsm == ST_PARAM) begin
          if (!flg.cap_sent) send = SB_CAP;
        end else if (fsm == ST_FDI) begin
          if (it.fdi_rxactive_status && o.fdi_rxactive_request && !flg.response_sent) begin
            send = SB_RSP;
          end else if (flg.activation_pending && !flg.request_sent) begin
            send = SB_REQ;
          end
        end
        o.sideband_send = send;
        case (fsm)
          ST_START: begin
            if (it.rdi_inband_present) nxt = ST_RDI;
          end
          ST_RDI: begin
            if (it.rdi_status == RDI_STS_ACTIVE) nxt = ST_PARAM;
          end
          ST_PARAM: begin
            nf.cap_received = flg.cap_received || (it.sideband_received == SB_CAP);
            nf.cap_sent = flg.cap_sent || (it.sideband_ready && send == SB_CAP);
            if (flg.cap_sent && flg.cap_received) nxt = ST_FDI;
          end
          ST_FDI: begin
            nf.peer_response_seen = flg.peer_response_seen || (it.sideband_received == SB_RSP);
            nf.peer_request_seen = flg.peer_request_seen || (it.sideband_received == SB_REQ);
            nf.response_sent = flg.response_sent || (send == SB_RSP && it.sideband_ready);
            nf.request_sent = flg.request_sent || (send == SB_REQ && it.sideband_ready);
            nf.activation_pending = flg.activation_pending ||
                (it.fdi_state_request == FDI_REQ_ACTIVE && it.fdi_state_request_prev == FDI_REQ_NOP);
            if (flg.response_sent && flg.peer_response_seen) nxt = ST_DONE;
          end
          default: begin
          end
        endcase
        fsm = nxt;
        flg = nf;
      end else begin
        fsm = ST_START;
        flg.cap_received = 1'b0;
        flg.cap_sent = 1'b0;
      end
      expected_outputs.push_back(o);
    endfunction

    function void judge(string field, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on %s at result %0d: expected %0h, got %0h",
                   field, results, want, got);
        end
      end
    endfunction

    function void check_outputs(out_item_t got);
      out_item_t want;
      if (expected_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result %0d arrived with nothing expected", results);
      end else begin
        want = expected_outputs.pop_front();
        judge("fdi_inband_present", want.fdi_inband_present, got.fdi_inband_present);
        judge("fdi_rxactive_request", want.fdi_rxactive_request, got.fdi_rxactive_request);
        judge("fdi_status", want.fdi_status, got.fdi_status);
        judge("rdi_state_request", want.rdi_state_request, got.rdi_state_request);
        judge("entry_done", want.entry_done, got.entry_done);
        judge("sideband_send", want.sideband_send, got.sideband_send);
      end
      results++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  link_init_scoreboard sb = new();
  int burst_left = 0;

  d2d_adapter_link_init_fsm i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_cycle(in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_outputs(out_item_t'(m_axis_tdata[$bits(out_item_t)-1:0]));
      end
    end
  end

  function automatic in_item_t mk(logic [3:0] link, logic inband, logic [3:0] rdi_sts,
                                  sb_msg_t rcv, logic rdy, logic rx_sts,
                                  logic [3:0] req, logic [3:0] req_prev);
    in_item_t it;
    it.link_mode = link;
    it.rdi_inband_present = inband;
    it.rdi_status = rdi_sts;
    it.sideband_received = rcv;
    it.sideband_ready = rdy;
    it.fdi_rxactive_status = rx_sts;
    it.fdi_state_request = req;
    it.fdi_state_request_prev = req_prev;
    return it;
  endfunction

  function automatic logic [3:0] pick_request();
    case ($urandom_range(0, 2))
      0: return FDI_REQ_ACTIVE;
      1: return FDI_REQ_NOP;
      default: return 4'($urandom);
    endcase
  endfunction

  // Cycle of a bring-up in progress: link held in reset, other fields biased to move it on.
  function automatic in_item_t flow_item();
    return mk(LINK_RESET, $urandom_range(0, 4) != 0,
              ($urandom_range(0, 9) < 7) ? RDI_STS_ACTIVE : 4'($urandom),
              sb_msg_t'($urandom_range(0, 3)), $urandom_range(0, 2) != 0,
              1'($urandom), pick_request(), pick_request());
  endfunction

  function automatic in_item_t noise_item();
    logic [31:0] raw;
    raw = $urandom;
    return in_item_t'(raw[$bits(in_item_t)-1:0]);
  endfunction

  task automatic offer(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tdata <= IN_TDATA_W'(item);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  initial begin : sink
    int seg;
    int len;
    int i;
    wait (!rst);
    @(posedge clk);
    seg = 0;
    forever begin
      len = $urandom_range(5, 60);
      if (seg % 37 == 3) begin
        m_axis_tready <= 1'b0;
        for (i = 0; i < 80; i++) @(posedge clk);
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            m_axis_tready <= 1'b1;
            repeat (len) @(posedge clk);
          end
          1: begin
            for (i = 0; i < len; i++) begin
              m_axis_tready <= 1'($urandom);
              @(posedge clk);
            end
          end
          default: begin
            for (i = 0; i < len; i++) begin
              m_axis_tready <= (i % 3 == 0);
              @(posedge clk);
            end
          end
        endcase
      end
      seg++;
    end
  end

  initial begin : stimulus
    int n;
    int sent;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Full bring-up walk through every state and message, with unknown codes on the way.
    offer(mk(4'hF, 1'b1, 4'hF, SB_RSP, 1'b1, 1'b1, 4'hF, 4'hF));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_NONE, 1'b0, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b1, 4'h0, SB_NONE, 1'b0, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b1, 4'hF, SB_NONE, 1'b0, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_REQ, 1'b1, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b0, RDI_STS_ACTIVE, SB_NONE, 1'b0, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_NONE, 1'b0, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_CAP, 1'b1, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_NONE, 1'b0, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_REQ, 1'b0, 1'b0, FDI_REQ_ACTIVE, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_NONE, 1'b0, 1'b0, FDI_REQ_ACTIVE, FDI_REQ_ACTIVE));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_RSP, 1'b1, 1'b1, FDI_REQ_NOP, FDI_REQ_ACTIVE));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_NONE, 1'b1, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b1, 4'hF, SB_CAP, 1'b1, 1'b1, 4'hF, 4'hF));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_NONE, 1'b0, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(4'h8, 1'b0, 4'h0, SB_NONE, 1'b0, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b1, 4'h0, SB_NONE, 1'b0, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    // Second walk: capability offered while the sideband is busy, then an unknown request.
    offer(mk(LINK_RESET, 1'b0, RDI_STS_ACTIVE, SB_NONE, 1'b0, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_CAP, 1'b0, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_NONE, 1'b1, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_NONE, 1'b0, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_NONE, 1'b1, 1'b1, 4'h2, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_NONE, 1'b1, 1'b0, FDI_REQ_ACTIVE, 4'hF));
    offer(mk(4'h1, 1'b0, 4'h0, SB_NONE, 1'b0, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));
    offer(mk(LINK_RESET, 1'b0, 4'h0, SB_NONE, 1'b0, 1'b0, FDI_REQ_NOP, FDI_REQ_NOP));

    // Mostly whole bring-ups with random content, each ended by leaving link reset.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 5);
        repeat (n) offer(noise_item());
      end else begin
        n = $urandom_range(8, 60);
        repeat (n) offer(flow_item());
        offer(mk(4'($urandom_range(1, 15)), 1'($urandom), 4'($urandom),
                 sb_msg_t'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                 4'($urandom), 4'($urandom)));
        n++;
      end
      sent += n;
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (sb.expected_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_outputs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
